/* sv/md5_pkg.sv */
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  cnt;
        logic        last;
    } t_item;

    function automatic logic [31:0] sine_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_s(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0: s = 5'd7;   4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] word_g(input logic [5:0] i);
        logic [3:0] g;
        case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = 4'(5 * i[3:0] + 1);
            2'd2: g = 4'(3 * i[3:0] + 5);
            default: g = 4'(7 * i[3:0]);
        endcase
        return g;
    endfunction

endpackage

/* sv/md5_message_digest.sv */
// MD5 message digest engine.
// Input channel: push / full. Each transaction carries up to four message
//   bytes in i_data_word (first byte in bits 7:0), i_byte_count (5..7 read as
//   4) and i_last_of_message, which closes the message.
// Result channel: empty / pop. A closed message yields four transactions,
//   digest words A, B, C, D; o_word_last marks D.
// A two-entry queue decouples intake from the hashing engine, so pushes
//   proceed while the engine works or results wait.
// Flow: the engine takes an item only when idle, moves its bytes into the
//   block buffer at one byte per cycle, pausing while a full 64-byte block
//   is compressed at one MD5 step per cycle through a single round unit;
//   it takes no new item until it is through with the last one.
// Closing a message adds padding at one byte per cycle, one or two block
//   compressions, then the four result transactions.
// If the receiver stalls, the engine holds the pending digest word and the
//   queue fills, after which full rises.
// Reset (synchronous, active low) loads the initial chaining words, clears
//   the byte count and length, and empties queue and output.
module md5_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_of_message,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest_word,
    output logic        o_word_last
);
    import md5_pkg::*;

    t_item w_item;
    logic  w_valid, w_take;

    md5_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push),
        .i_data_word(i_data_word), .i_byte_count(i_byte_count),
        .i_last_of_message(i_last_of_message), .o_full(full),
        .o_item(w_item), .o_valid(w_valid), .i_take(w_take)
    );

    md5_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(w_item), .i_valid(w_valid),
        .o_take(w_take), .o_digest_word(o_digest_word),
        .o_word_last(o_word_last), .o_empty(empty), .i_pop(pop)
    );

    // a stalled result must hold its word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_digest_word) && $stable(o_word_last)))
        else $error("result changed while stalled");
    // the engine only takes from a non-empty queue path when idle
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_valid) |=> !w_take)
        else $error("engine took an item without leaving idle");
endmodule

/* sv/md5_front.sv */
module md5_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [31:0]   i_data_word,
    input  logic [2:0]    i_byte_count,
    input  logic          i_last_of_message,
    output logic          o_full,
    output md5_pkg::t_item o_item,
    output logic          o_valid,
    input  logic          i_take
);
    import md5_pkg::*;

    // two-entry queue between intake and the hashing engine
    t_item      r_q [2];
    logic [1:0] r_cnt;
    logic       r_wp, r_rp;
    t_item      w_in;
    logic       w_wr, w_rd;

    always_comb begin
        w_in.word = i_data_word;
        w_in.cnt  = (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;
        w_in.last = i_last_of_message;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    // drop empty non-last items at the door
    assign w_wr = i_push && !o_full && (w_in.cnt != 3'd0 || w_in.last);
    assign w_rd = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_wr) r_wp <= !r_wp;
            if (w_rd) r_rp <= !r_rp;
            r_cnt <= 2'(r_cnt + {1'b0, w_wr} - {1'b0, w_rd});
        end
        if (w_wr) r_q[r_wp] <= w_in;
    end
endmodule

/* sv/md5_core.sv */
module md5_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  md5_pkg::t_item i_item,
    input  logic          i_valid,
    output logic          o_take,
    output logic [31:0]   o_digest_word,
    output logic          o_word_last,
    output logic          o_empty,
    input  logic          i_pop
);
    import md5_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_BYTE = 7'b0000010,
        S_PAD  = 7'b0000100,
        S_ZERO = 7'b0001000,
        S_LEN  = 7'b0010000,
        S_HASH = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state      r_state;
    logic [31:0] r_buf [16];
    logic [31:0] r_h [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [5:0]  r_fill, r_step;
    logic [60:0] r_len;
    t_item       r_item;
    logic [2:0]  r_bi;
    logic [1:0]  r_oi;
    logic        r_fin, r_ret_zero;
    logic        r_ovld;
    logic [31:0] r_ow;
    logic        r_ol;

    logic [31:0] w_f, w_t, w_rot, w_x;
    logic [63:0] w_bits;
    logic [7:0]  w_byte;

    assign w_bits = {r_len, 3'b000};
    assign w_x = r_buf[word_g(r_step)];
    always_comb begin
        case (r_step[5:4])
            2'd0: w_f = (r_b & r_c) | (~r_b & r_d);
            2'd1: w_f = (r_b & r_d) | (r_c & ~r_d);
            2'd2: w_f = r_b ^ r_c ^ r_d;
            default: w_f = r_c ^ (r_b | ~r_d);
        endcase
    end
    assign w_t   = r_a + w_f + w_x + sine_k(r_step);
    assign w_rot = (w_t << rot_s(r_step)) | (w_t >> (6'd32 - {1'b0, rot_s(r_step)}));
    assign w_byte = r_item.word[8*r_bi +: 8];

    assign o_take = (r_state == S_IDLE);
    assign o_empty = !r_ovld;
    assign o_digest_word = r_ow;
    assign o_word_last = r_ol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_h[0] <= IV_A; r_h[1] <= IV_B; r_h[2] <= IV_C; r_h[3] <= IV_D;
            r_fill <= 6'd0;
            r_len  <= 61'd0;
            r_ovld <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_ovld || i_pop)) r_ovld <= 1'b1;
            else if (r_ovld && i_pop) r_ovld <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_item <= i_item;
                    r_bi <= 3'd0;
                    r_state <= (i_item.cnt != 3'd0) ? S_BYTE : S_PAD;
                end
                S_BYTE: begin
                    r_buf[r_fill[5:2]][8*r_fill[1:0] +: 8] <= w_byte;
                    r_fill <= 6'(r_fill + 1);
                    r_len  <= 61'(r_len + 1);
                    r_bi   <= 3'(r_bi + 1);
                    r_fin  <= 1'b0;
                    if (r_fill == 6'd63) begin
                        r_step <= 6'd0;
                        r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3];
                        r_ret_zero <= 1'b0;
                        r_state <= S_HASH;
                    end else if (3'(r_bi + 3'd1) == r_item.cnt)
                        r_state <= r_item.last ? S_PAD : S_IDLE;
                end
                S_PAD: begin
                    r_buf[r_fill[5:2]][8*r_fill[1:0] +: 8] <= PAD_BYTE;
                    r_fill <= 6'(r_fill + 1);
                    r_fin <= 1'b1;
                    r_ret_zero <= 1'b0;
                    r_state <= S_ZERO;
                end
                S_ZERO: begin
                    if (r_fill == 6'd0 && !r_ret_zero) begin
                        // spill: padding overflowed into an extra block
                        r_step <= 6'd0;
                        r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3];
                        r_ret_zero <= 1'b1;
                        r_state <= S_HASH;
                    end else if (r_fill == 6'd56) begin
                        r_state <= S_LEN;
                    end else begin
                        r_buf[r_fill[5:2]][8*r_fill[1:0] +: 8] <= 8'h00;
                        r_fill <= 6'(r_fill + 1);
                    end
                end
                S_LEN: begin
                    r_buf[14] <= w_bits[31:0];
                    r_buf[15] <= w_bits[63:32];
                    r_fill <= 6'd0;
                    r_step <= 6'd0;
                    r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3];
                    r_ret_zero <= 1'b0;
                    r_state <= S_HASH;
                end
                S_HASH: begin
                    r_a <= r_d; r_d <= r_c; r_c <= r_b;
                    r_b <= r_b + w_rot;
                    r_step <= 6'(r_step + 1);
                    if (r_step == 6'd63) begin
                        r_h[0] <= r_h[0] + r_d;
                        r_h[1] <= r_h[1] + r_b + w_rot;
                        r_h[2] <= r_h[2] + r_b;
                        r_h[3] <= r_h[3] + r_c;
                        r_oi <= 2'd0;
                        if (r_ret_zero) r_state <= S_ZERO;
                        else if (r_fin) r_state <= S_OUT;
                        else if (r_bi == r_item.cnt)
                            r_state <= r_item.last ? S_PAD : S_IDLE;
                        else r_state <= S_BYTE;
                    end
                end
                S_OUT: if (!r_ovld || i_pop) begin
                    r_ow <= r_h[r_oi];
                    r_ol <= (r_oi == 2'd3);
                    r_oi <= 2'(r_oi + 1);
                    if (r_oi == 2'd3) begin
                        r_h[0] <= IV_A; r_h[1] <= IV_B; r_h[2] <= IV_C; r_h[3] <= IV_D;
                        r_fill <= 6'd0;
                        r_len <= 61'd0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

// Scoreboard: keeps an MD5 engine of its own and a queue of expected digest words.
class md5_digest_board;
    logic [31:0] chain[4];
    logic [7:0]  buf_bytes[64];
    int unsigned fill;
    logic [60:0] msg_len;
    logic [31:0] exp_word[$];
    logic        exp_last[$];
    int unsigned mismatches;
    int unsigned words_checked;
    int unsigned digests;
    int unsigned compressions;

    function new();
        mismatches = 0;
        words_checked = 0;
        digests = 0;
        compressions = 0;
        start_message();
    endfunction

    function void start_message();
        chain[0] = md5_pkg::IV_A;
        chain[1] = md5_pkg::IV_B;
        chain[2] = md5_pkg::IV_C;
        chain[3] = md5_pkg::IV_D;
        fill = 0;
        msg_len = '0;
    endfunction

    function logic [31:0] round_const(int i);
        logic [31:0] tab[64];
        tab = '{32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
                32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
                32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
                32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
                32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
                32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
                32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
                32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
                32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
                32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
                32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
                32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
                32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
                32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
                32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
                32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
        return tab[i];
    endfunction

    function void compress();
        logic [31:0] x[16];
        logic [31:0] a, b, c, d, f, t;
        int shifts[16];
        int sel, rnd, s;
        shifts = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
        for (int i = 0; i < 16; i++)
            x[i] = {buf_bytes[4*i+3], buf_bytes[4*i+2], buf_bytes[4*i+1], buf_bytes[4*i]};
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        for (int i = 0; i < 64; i++) begin
            rnd = i / 16;
            case (rnd)
                0: begin f = (b & c) | (~b & d); sel = i; end
                1: begin f = (b & d) | (c & ~d); sel = (5 * i + 1) % 16; end
                2: begin f = b ^ c ^ d;          sel = (3 * i + 5) % 16; end
                default: begin f = c ^ (b | ~d); sel = (7 * i) % 16; end
            endcase
            s = shifts[rnd * 4 + i % 4];
            t = a + f + x[sel] + round_const(i);
            t = b + ((t << s) | (t >> (32 - s)));
            a = d; d = c; c = b; b = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        compressions++;
    endfunction

    function void add_byte(logic [7:0] v);
        buf_bytes[fill] = v;
        fill++;
        if (fill == 64) begin
            compress();
            fill = 0;
        end
    endfunction

    // Note one accepted input transaction; queue the digest when it closes a message.
    function void note_item(logic [31:0] word, logic [2:0] cnt, logic last);
        int n;
        logic [63:0] bits;
        n = (cnt > 3'd4) ? 4 : int'(cnt);
        for (int i = 0; i < n; i++) begin
            add_byte(word[8*i +: 8]);
            msg_len = msg_len + 61'd1;
        end
        if (!last) return;
        bits = {msg_len, 3'b000};
        buf_bytes[fill] = md5_pkg::PAD_BYTE;
        fill++;
        if (fill > 56) begin
            for (int i = fill; i < 64; i++) buf_bytes[i] = 8'h00;
            compress();
            fill = 0;
        end
        for (int i = fill; i < 56; i++) buf_bytes[i] = 8'h00;
        for (int i = 0; i < 8; i++) buf_bytes[56 + i] = bits[8*i +: 8];
        compress();
        for (int i = 0; i < 4; i++) begin
            exp_word.push_back(chain[i]);
            exp_last.push_back(i == 3);
        end
        digests++;
        start_message();
    endfunction

    // Compare one accepted result transaction with the oldest expected word.
    function void check_word(logic [31:0] word, logic last);
        logic [31:0] ew;
        logic el;
        if (exp_word.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected digest word %h last %b", word, last);
            return;
        end
        ew = exp_word.pop_front();
        el = exp_last.pop_front();
        words_checked++;
        if (word !== ew || last !== el) begin
            mismatches++;
            if (mismatches <= 10)
                $display("digest mismatch: expected %h last %b, got %h last %b",
                         ew, el, word, last);
        end
    endfunction
endclass

module tb;
    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [31:0] i_data_word;
    logic [2:0]  i_byte_count;
    logic        i_last_of_message;
    logic        empty;
    logic        pop;
    logic [31:0] o_digest_word;
    logic        o_word_last;

    localparam int CYCLE_LIMIT = 400000;

    md5_digest_board board;
    int unsigned cycle_count;
    bit          quiet_phase;   // no idling on either side
    bit          hold_off_req;  // ask the receiver for a long stall
    bit          hold_off_active;
    int unsigned items_sent;
    int unsigned full_seen;

    md5_message_digest u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_data_word       (i_data_word),
        .i_byte_count      (i_byte_count),
        .i_last_of_message (i_last_of_message),
        .empty             (empty),
        .pop               (pop),
        .o_digest_word     (o_digest_word),
        .o_word_last       (o_word_last)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // Sample accepted results at the rising edge and count cycles in which a push meets full.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            board.check_word(o_digest_word, o_word_last);
        if (i_rst_n && push && full)
            full_seen++;
    end

    // Receiver: pop with random idle bursts; hold off for a long stretch on request.
    initial begin
        int unsigned gap;
        pop = 1'b0;
        hold_off_active = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                pop <= 1'b0;
                hold_off_active = 1'b1;
                repeat (600) @(negedge i_clk);
                hold_off_active = 1'b0;
                hold_off_req = 1'b0;
            end
            if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 15);
                pop <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Offer one transaction and hold it until accepted; idle randomly beforehand.
    // Push stays high afterwards so the next transaction can follow at once.
    task automatic send_item(input logic [31:0] word, input logic [2:0] cnt,
                             input logic last);
        int unsigned gap;
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 15);
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_data_word <= word;
        i_byte_count <= cnt;
        i_last_of_message <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        board.note_item(word, cnt, last);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Random message of len_items transactions with random counts, closed by a last item.
    task automatic send_message(input int len_items);
        logic [2:0] cnt;
        for (int i = 0; i < len_items; i++) begin
            cnt = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
            send_item($urandom, cnt, i == len_items - 1);
        end
    endtask

    initial begin
        int idle_wait;
        board = new();
        cycle_count = 0;
        quiet_phase = 1'b0;
        hold_off_req = 1'b0;
        items_sent = 0;
        full_seen = 0;
        push = 1'b0;
        i_data_word = '0;
        i_byte_count = '0;
        i_last_of_message = 1'b0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty message, "abc", extreme words, oversize counts, empty non-last.
        send_item(32'h0, 3'd0, 1'b1);
        send_item(32'h00636261, 3'd3, 1'b1);
        send_item(32'hFFFFFFFF, 3'd4, 1'b0);
        send_item(32'h00000000, 3'd4, 1'b0);
        send_item(32'hDEADBEEF, 3'd0, 1'b0);
        send_item(32'hA5A5A5A5, 3'd5, 1'b0);
        send_item(32'h5A5A5A5A, 3'd6, 1'b0);
        send_item(32'h12345678, 3'd7, 1'b0);
        send_item(32'hFFFFFFFF, 3'd1, 1'b0);
        send_item(32'hFFFFFFFF, 3'd2, 1'b1);
        // 56 bytes: padding spills into an extra block.
        for (int i = 0; i < 14; i++) send_item($urandom, 3'd4, i == 13);
        // 55 bytes then an empty last item: padding just fits.
        for (int i = 0; i < 14; i++) send_item($urandom, (i == 13) ? 3'd3 : 3'd4, 1'b0);
        send_item(32'hFFFFFFFF, 3'd0, 1'b1);

        // Random messages, mostly short; the long stall fires partway through.
        while (items_sent < 160) begin
            if (board.digests == 6 && !hold_off_req && !hold_off_active)
                hold_off_req = 1'b1;
            if ($urandom_range(0, 7) == 0) send_message($urandom_range(15, 40));
            else send_message($urandom_range(1, 8));
        end
        // Final part with no idling.
        quiet_phase = 1'b1;
        for (int m = 0; m < 4; m++) send_message($urandom_range(1, 6));
        push <= 1'b0;

        idle_wait = 0;
        while (board.exp_word.size() != 0 && idle_wait < 20000) begin
            @(posedge i_clk);
            idle_wait++;
        end
        repeat (300) @(posedge i_clk);

        $display("covered %0d transactions, %0d digests, %0d block compressions",
                 items_sent, board.digests, board.compressions);
        $display("checked %0d digest words, input stalled on full %0d cycles, %0d mismatches",
                 board.words_checked, full_seen, board.mismatches);
        if (board.mismatches == 0 && board.exp_word.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
